@@ hw/rtl/swlru_pkg.sv @@
// shared types and constants for the size weighted lru buffer table
package swlru_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_ERASE  = 2'd1;
	localparam logic [1:0] KIND_TOUCH  = 2'd2;
	localparam logic [1:0] KIND_REDUCE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [15:0] array_id;
		logic [15:0] attribute_id;
		logic [31:0] chunk_index;
		logic [31:0] chunk_bytes;
	} entry_t;

	// per-cell command, the same for every cell of the row
	typedef struct packed {
		logic   compare;  // register match flags against key
		logic   shift;    // close gap: cells at or above pos take right neighbor
		logic   append;   // cell at index cnt takes new entry
		entry_t key;      // key and size for compare and append
	} cell_cmd_t;

endpackage

@@ hw/rtl/swlru_cell.sv @@
// one slot of the recency row: holds an entry, compares and shifts
module swlru_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swlru_pkg::cell_cmd_t    cmd,
	input  logic                    shift_en,
	input  logic                    append_en,
	input  swlru_pkg::entry_t       right_entry,
	input  logic                    right_valid,
	output swlru_pkg::entry_t       entry,
	output logic                    valid,
	output logic                    hit
);
	swlru_pkg::entry_t entry_q;
	logic              valid_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		if (append_en) begin
			entry_q <= cmd.key;
		end else if (shift_en) begin
			entry_q <= right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (append_en) begin
				valid_q <= 1'b1;
			end else if (shift_en) begin
				valid_q <= right_valid;
			end
			if (cmd.compare) begin
				hit_q <= valid_q && entry_q.array_id == cmd.key.array_id &&
					entry_q.attribute_id == cmd.key.attribute_id &&
					entry_q.chunk_index == cmd.key.chunk_index;
			end
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign hit   = hit_q;
endmodule

@@ hw/rtl/size_weighted_lru_buffer_table.sv @@
// top level: recency ordered buffer table built from a row of slot cells
//
//  channel  dir  tdata fields (low bit up)                                tuser / tlast
//  s_axis   in   array_id, attribute_id, chunk_index, chunk_bytes,        tuser: kind
//                target_bytes (136 bits)
//  m_axis   out  evicted_array_id, evicted_attribute_id, evicted_chunk_   tuser: status,
//                index, evicted_bytes, total_after (136 bits)              evicted; tlast
//
// insert, erase and touch step through accept, compare in the cell row, priority
// encode of the hit together with the shift, then append and result.
// reduce gives its evictions by turns of shift, then test of the new total.
// reset clears the valid bits, the count and the total at once; one item at a
// time, and the output register holds a result while m_axis_tready is low.
module size_weighted_lru_buffer_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// array_id, attribute_id, chunk_index, chunk_bytes, target_bytes
	input  logic [135:0]  s_axis_tdata,
	// kind
	input  logic [1:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// evicted_array_id, evicted_attribute_id, evicted_chunk_index, evicted_bytes,
	// total_after
	output logic [135:0]  m_axis_tdata,
	// status, evicted
	output logic [2:0]    m_axis_tuser,
	output logic          m_axis_tlast
);
	localparam int D  = swlru_pkg::TABLE_DEPTH;
	localparam int PW = $clog2(D);
	localparam int CW = swlru_pkg::CNT_W;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CMP   = 6'b000010,
		S_FIND  = 6'b000100,
		S_APPLY = 6'b001000,
		S_RED   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t               state_q;
	logic [1:0]           kind_q;
	swlru_pkg::entry_t    key_q;
	logic [39:0]          target_q;
	logic [39:0]          total_q;
	logic [CW-1:0]        cnt_q;
	logic [PW-1:0]        pos_q;
	logic                 found_q;
	logic                 ovalid_q;
	logic [135:0]         odata_q;
	logic [2:0]           ouser_q;
	logic                 olast_q;

	swlru_pkg::cell_cmd_t cmd;
	swlru_pkg::entry_t    ent [D];
	logic [D-1:0]         vld;
	logic [D-1:0]         hit;
	logic [D-1:0]         sh_en;
	logic [D-1:0]         ap_en;
	logic                 do_shift;
	logic                 do_append;
	logic [PW-1:0]        hit_pos;
	logic                 hit_any;
	logic [PW-1:0]        shift_pos;
	logic                 out_free;
	logic                 out_load;
	logic                 red_go;

	// the hit position is used in the same cycle it is encoded
	assign shift_pos = (state_q == S_FIND) ? hit_pos : pos_q;

	genvar g;
	generate
		for (g = 0; g < D; g++) begin : g_cell
			swlru_pkg::entry_t re;
			logic              rv;
			if (g == D - 1) begin : g_end
				assign re = ent[g];
				assign rv = 1'b0;
			end else begin : g_mid
				assign re = ent[g+1];
				assign rv = vld[g+1];
			end
			assign sh_en[g] = do_shift && (PW'(g) >= shift_pos);
			assign ap_en[g] = do_append && (cnt_q == CW'(g));
			swlru_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd),
				.shift_en(sh_en[g]), .append_en(ap_en[g]),
				.right_entry(re), .right_valid(rv),
				.entry(ent[g]), .valid(vld[g]), .hit(hit[g])
			);
		end
	endgenerate

	always_comb begin
		hit_pos = '0;
		hit_any = 1'b0;
		for (int i = D - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_pos = PW'(i);
				hit_any = 1'b1;
			end
		end
	end

	assign out_free = !ovalid_q || m_axis_tready;
	assign out_load = out_free && (state_q == S_APPLY || state_q == S_RED);
	assign s_axis_tready = (state_q == S_IDLE);

	assign red_go = (total_q > target_q) && vld[0];

	always_comb begin
		cmd.compare = (state_q == S_CMP);
		cmd.key     = key_q;
		cmd.shift   = 1'b0;
		cmd.append  = 1'b0;
		do_shift    = 1'b0;
		do_append   = 1'b0;
		if (state_q == S_FIND && hit_any && kind_q != swlru_pkg::KIND_REDUCE) begin
			do_shift = 1'b1;
		end
		if (state_q == S_APPLY &&
			(kind_q == swlru_pkg::KIND_INSERT ||
			(kind_q == swlru_pkg::KIND_TOUCH && found_q))) begin
			do_append = 1'b1;
		end
		if (state_q == S_RED && red_go && out_free) begin
			do_shift = 1'b1;
		end
		cmd.shift  = do_shift;
		cmd.append = do_append;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			key_q.array_id     <= s_axis_tdata[15:0];
			key_q.attribute_id <= s_axis_tdata[31:16];
			key_q.chunk_index  <= s_axis_tdata[63:32];
			key_q.chunk_bytes  <= s_axis_tdata[95:64];
			target_q           <= s_axis_tdata[135:96];
			kind_q             <= s_axis_tuser;
		end else if (state_q == S_FIND && hit_any && kind_q == swlru_pkg::KIND_TOUCH) begin
			key_q.chunk_bytes <= ent[hit_pos].chunk_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			total_q  <= '0;
			cnt_q    <= '0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			ovalid_q <= 1'b0;
			odata_q  <= '0;
			ouser_q  <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					pos_q <= '0;
					if (s_axis_tvalid) begin
						state_q <= (s_axis_tuser == swlru_pkg::KIND_REDUCE) ? S_RED : S_CMP;
					end
				end
				S_CMP: state_q <= S_FIND;
				S_FIND: begin
					found_q <= hit_any;
					pos_q   <= hit_pos;
					if (hit_any) begin
						cnt_q <= cnt_q - CW'(1);
						if (kind_q == swlru_pkg::KIND_INSERT ||
							kind_q == swlru_pkg::KIND_ERASE) begin
							total_q <= total_q - 40'(ent[hit_pos].chunk_bytes);
						end
					end
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (out_free) begin
						olast_q <= 1'b1;
						if (kind_q == swlru_pkg::KIND_INSERT) begin
							if (!found_q && cnt_q == CW'(D)) begin
								ouser_q <= {1'b0, swlru_pkg::ST_FULL};
								odata_q <= {total_q, 96'd0};
							end else begin
								cnt_q   <= cnt_q + CW'(1);
								ouser_q <= {1'b0, swlru_pkg::ST_OK};
								odata_q <= {total_q + 40'(key_q.chunk_bytes), 96'd0};
								total_q <= total_q + 40'(key_q.chunk_bytes);
							end
						end else if (!found_q) begin
							ouser_q <= {1'b0, swlru_pkg::ST_NOTFOUND};
							odata_q <= {total_q, 96'd0};
						end else begin
							if (kind_q == swlru_pkg::KIND_TOUCH) begin
								cnt_q <= cnt_q + CW'(1);
							end
							ouser_q <= {1'b0, swlru_pkg::ST_OK};
							odata_q <= {total_q, 96'd0};
						end
						state_q <= S_IDLE;
					end
				end
				S_RED: begin
					if (out_free) begin
						if (red_go) begin
							ouser_q  <= {1'b1, swlru_pkg::ST_OK};
							odata_q  <= {total_q - 40'(ent[0].chunk_bytes),
								ent[0].chunk_bytes, ent[0].chunk_index,
								ent[0].attribute_id, ent[0].array_id};
							olast_q  <= 1'b0;
							total_q  <= total_q - 40'(ent[0].chunk_bytes);
							cnt_q    <= cnt_q - CW'(1);
							state_q  <= S_OUT;
						end else begin
							ouser_q  <= {1'b0, swlru_pkg::ST_OK};
							odata_q  <= {total_q, 96'd0};
							olast_q  <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				S_OUT: begin
					// decide last on the word just issued, before anyone takes it
					olast_q <= !red_go;
					state_q <= red_go ? S_RED : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q && (state_q != S_OUT);
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ouser_q;
	assign m_axis_tlast  = olast_q;
endmodule
